// ----- rtl/fcc_pkg.sv -----
// Shared types, constants and helper functions of the cluster chain allocator.
package fcc_pkg;

  localparam logic [15:0] FREE_ENTRY = 16'h0000;
  localparam logic [15:0] BAD_MARK   = 16'hFFF7;
  localparam logic [15:0] END_LOW    = 16'hFFF8;
  localparam logic [15:0] END_MARK   = 16'hFFFF;
  localparam int          FIRST_DATA = 2;

  localparam logic [1:0] K_WRITE  = 2'd0;
  localparam logic [1:0] K_READ   = 2'd1;
  localparam logic [1:0] K_EXTEND = 2'd2;
  localparam logic [1:0] K_SHRINK = 2'd3;

  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_CLUSTER_LOG2  = 1'b1;

  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    logic [15:0] wdata;
    logic [15:0] raddr;
  } mreq_t;

  function automatic logic is_stop(input logic [15:0] link, input logic [16:0] depth);
    return (link >= END_LOW) || (link == BAD_MARK) || ({1'b0, link} >= depth);
  endfunction

  function automatic logic [32:0] cluster_span(input logic [31:0] size, input logic [4:0] sh);
    logic [31:0] mask;
    mask = 32'((33'd1 << sh) - 33'd1);
    return 33'(size >> sh) + 33'(|(size & mask));
  endfunction

endpackage

// ----- rtl/fcc_table.sv -----
// Allocation table memory with one write port and one registered read port.
module fcc_table #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic              clk,
  input  fcc_pkg::mreq_t    mreq,
  output logic [15:0]       rdata_r
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [15:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr[AW-1:0]] <= mreq.wdata;
    end
    rdata_r <= mem[mreq.raddr[AW-1:0]];
  end

endmodule

// ----- rtl/fcc_ctrl.sv -----
// Sequencer that clears the table after reset, writes and reads entries, and walks, counts, links and frees chains.
module fcc_ctrl #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      kind,
  input  logic [11:0]     entry_index,
  input  logic [15:0]     entry_value,
  input  logic [15:0]     start_cluster,
  input  logic [32:0]     old_cnt,
  input  logic [32:0]     new_cnt,
  input  logic [12:0]     cluster_count,
  output fcc_pkg::mreq_t  mreq,
  input  logic [15:0]     rdata,
  output logic            out_strobe,
  output logic            out_status,
  output logic [15:0]     out_value
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);
  localparam logic [AW:0] LAST_ADDR = (AW+1)'(TABLE_DEPTH - 1);
  localparam logic [AW:0] FIRST_F = (AW+1)'(fcc_pkg::FIRST_DATA);

  typedef enum logic [14:0] {
    S_CLR  = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_RDAT = 15'b000000000000100,
    S_WRD  = 15'b000000000001000,
    S_WDAT = 15'b000000000010000,
    S_CRD  = 15'b000000000100000,
    S_CDAT = 15'b000000001000000,
    S_LRD  = 15'b000000010000000,
    S_LDAT = 15'b000000100000000,
    S_LEND = 15'b000001000000000,
    S_TRD  = 15'b000010000000000,
    S_TDAT = 15'b000100000000000,
    S_FRD  = 15'b001000000000000,
    S_FDAT = 15'b010000000000000,
    S_SPARE = 15'b100000000000000
  } state_t;

  state_t       st_r, st_nxt, post_st;
  logic [AW:0]  f_r, f_nxt;
  logic [AW:0]  fc_r, fc_nxt, fc_inc;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [32:0]  cnt_r, cnt_nxt;
  logic [32:0]  wlim_r, wlim_nxt;
  logic [32:0]  need_r, need_nxt;
  logic [15:0]  tf_r, tf_nxt;
  logic [1:0]   kind_r, kind_nxt;
  logic         ov_r, ov_nxt;
  logic         os_r, os_nxt;
  logic [15:0]  oval_r, oval_nxt;
  logic [16:0]  lim17;
  logic         eligible;

  assign busy       = (st_r != S_IDLE);
  assign out_strobe = ov_r;
  assign out_status = os_r;
  assign out_value  = oval_r;
  assign fc_inc     = fc_r + 1'b1;
  assign lim17      = ({4'b0, cluster_count} < DEPTH17) ? {4'b0, cluster_count} : DEPTH17;
  assign post_st    = (kind_r == fcc_pkg::K_EXTEND) ? S_CRD : S_TRD;
  assign eligible   = (rdata == fcc_pkg::FREE_ENTRY) &&
                      !((f_r[AW-1:0] == cur_r) && (fc_r != '0));

  always_comb begin
    st_nxt   = st_r;
    f_nxt    = f_r;
    fc_nxt   = fc_r;
    cur_nxt  = cur_r;
    cnt_nxt  = cnt_r;
    wlim_nxt = wlim_r;
    need_nxt = need_r;
    tf_nxt   = tf_r;
    kind_nxt = kind_r;
    ov_nxt   = 1'b0;
    os_nxt   = os_r;
    oval_nxt = oval_r;
    mreq     = '0;
    case (st_r)
      S_CLR: begin
        mreq.we    = 1'b1;
        mreq.waddr = 16'(f_r[AW-1:0]);
        mreq.wdata = fcc_pkg::FREE_ENTRY;
        if (f_r == LAST_ADDR) begin
          f_nxt  = '0;
          st_nxt = S_IDLE;
        end else begin
          f_nxt = f_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt = kind;
          cur_nxt  = start_cluster[AW-1:0];
          cnt_nxt  = 33'd1;
          need_nxt = new_cnt - old_cnt;
          wlim_nxt = (kind == fcc_pkg::K_EXTEND) ? old_cnt : new_cnt;
          os_nxt   = 1'b0;
          oval_nxt = '0;
          case (kind)
            fcc_pkg::K_WRITE: begin
              if ({5'b0, entry_index} < DEPTH17) begin
                mreq.we    = 1'b1;
                mreq.waddr = {4'b0, entry_index};
                mreq.wdata = entry_value;
              end
              ov_nxt = 1'b1;
            end
            fcc_pkg::K_READ: begin
              if ({5'b0, entry_index} < DEPTH17) begin
                mreq.raddr = {4'b0, entry_index};
                st_nxt     = S_RDAT;
              end else begin
                ov_nxt = 1'b1;
              end
            end
            default: begin
              if ({1'b0, start_cluster} >= DEPTH17) begin
                ov_nxt = 1'b1;
              end else if (kind == fcc_pkg::K_EXTEND && new_cnt <= old_cnt) begin
                ov_nxt = 1'b1;
              end else if (kind == fcc_pkg::K_SHRINK && new_cnt >= old_cnt) begin
                ov_nxt = 1'b1;
              end else begin
                st_nxt = S_WRD;
              end
            end
          endcase
        end
      end
      S_RDAT: begin
        ov_nxt   = 1'b1;
        oval_nxt = rdata;
        st_nxt   = S_IDLE;
      end
      S_WRD: begin
        if (cnt_r < wlim_r) begin
          mreq.raddr = 16'(cur_r);
          st_nxt     = S_WDAT;
        end else begin
          f_nxt  = FIRST_F;
          fc_nxt = '0;
          st_nxt = post_st;
        end
      end
      S_WDAT: begin
        if (fcc_pkg::is_stop(rdata, DEPTH17)) begin
          f_nxt  = FIRST_F;
          fc_nxt = '0;
          st_nxt = post_st;
        end else begin
          cur_nxt = rdata[AW-1:0];
          cnt_nxt = cnt_r + 33'd1;
          st_nxt  = S_WRD;
        end
      end
      S_CRD: begin
        if ({{(16-AW){1'b0}}, f_r} >= lim17) begin
          ov_nxt = 1'b1;
          os_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          mreq.raddr = 16'(f_r[AW-1:0]);
          st_nxt     = S_CDAT;
        end
      end
      S_CDAT: begin
        if (eligible && 33'(fc_inc) == need_r) begin
          f_nxt  = FIRST_F;
          fc_nxt = '0;
          st_nxt = S_LRD;
        end else begin
          if (eligible) begin
            fc_nxt = fc_inc;
          end
          f_nxt  = f_r + 1'b1;
          st_nxt = S_CRD;
        end
      end
      S_LRD: begin
        mreq.raddr = 16'(f_r[AW-1:0]);
        st_nxt     = S_LDAT;
      end
      S_LDAT: begin
        if (rdata == fcc_pkg::FREE_ENTRY) begin
          mreq.we    = 1'b1;
          mreq.waddr = 16'(cur_r);
          mreq.wdata = 16'(f_r[AW-1:0]);
          st_nxt     = S_LEND;
        end else begin
          f_nxt  = f_r + 1'b1;
          st_nxt = S_LRD;
        end
      end
      S_LEND: begin
        mreq.we    = 1'b1;
        mreq.waddr = 16'(f_r[AW-1:0]);
        mreq.wdata = fcc_pkg::END_MARK;
        cur_nxt    = f_r[AW-1:0];
        if (33'(fc_inc) == need_r) begin
          ov_nxt   = 1'b1;
          oval_nxt = 16'(fc_inc);
          st_nxt   = S_IDLE;
        end else begin
          fc_nxt = fc_inc;
          f_nxt  = f_r + 1'b1;
          st_nxt = S_LRD;
        end
      end
      S_TRD: begin
        mreq.raddr = 16'(cur_r);
        st_nxt     = S_TDAT;
      end
      S_TDAT: begin
        mreq.we    = 1'b1;
        mreq.waddr = 16'(cur_r);
        mreq.wdata = fcc_pkg::END_MARK;
        tf_nxt     = rdata;
        st_nxt     = S_FRD;
      end
      S_FRD: begin
        if (tf_r == fcc_pkg::FREE_ENTRY || fcc_pkg::is_stop(tf_r, DEPTH17)) begin
          ov_nxt   = 1'b1;
          oval_nxt = 16'(fc_r);
          st_nxt   = S_IDLE;
        end else begin
          mreq.raddr = {{(16-AW){1'b0}}, tf_r[AW-1:0]};
          st_nxt     = S_FDAT;
        end
      end
      S_FDAT: begin
        mreq.we    = 1'b1;
        mreq.waddr = {{(16-AW){1'b0}}, tf_r[AW-1:0]};
        mreq.wdata = fcc_pkg::FREE_ENTRY;
        tf_nxt     = rdata;
        fc_nxt     = fc_inc;
        st_nxt     = S_FRD;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      f_r  <= '0;
      fc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      f_r  <= f_nxt;
      fc_r <= fc_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    cnt_r  <= cnt_nxt;
    wlim_r <= wlim_nxt;
    need_r <= need_nxt;
    tf_r   <= tf_nxt;
    kind_r <= kind_nxt;
    os_r   <= os_nxt;
    oval_r <= oval_nxt;
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && !start) |-> !mreq.we)
    else $error("table written while idle");

  a_fail_from_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r) |-> $past(st_r == S_CRD))
    else $error("failure beat not from free count pass");

  a_link_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LEND) |-> (mreq.we && mreq.wdata == fcc_pkg::END_MARK))
    else $error("new cluster not terminated");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && st_r != S_CLR) |=> st_r != S_CLR)
    else $error("clearing pass restarted");

endmodule

// ----- rtl/fat_cluster_chain_resize.sv -----
// FAT16 cluster chain allocator: configuration registers, size conversion and table.
//
// After reset the table is cleared one entry per cycle, up to TABLE_DEPTH-1, with busy high.
// A write or read entry item is one access to the table. A resize first walks the chain to
// the old length for an extend or the new length for a shrink; then an extend scans the
// entries in a free count pass and again in a link pass that links each new cluster, and a
// shrink frees the clusters past the new end. Every step is one access to the table memory
// with its registered read. The walk is bounded only by the cluster count derived from the
// byte size, not by the table, so a cyclic chain can hold a resize busy far beyond one
// table pass. One result beat follows each item on out_strobe for one cycle and cannot be
// held off.
module fat_cluster_chain_resize #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [11:0] in_entry_index,
  input  logic [15:0] in_entry_value,
  input  logic [15:0] in_start_cluster,
  input  logic [31:0] in_old_size,
  input  logic [31:0] in_new_size,
  output logic        out_strobe,
  output logic        out_status,
  output logic [15:0] out_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0]    cc_r;
  logic [4:0]     lg_r;
  logic [32:0]    old_cnt;
  logic [32:0]    new_cnt;
  logic           wr_en;
  logic [15:0]    rdata;
  fcc_pkg::mreq_t mreq;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == fcc_pkg::REG_CLUSTER_LOG2) ? {27'b0, lg_r} : {19'b0, cc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= 13'd4096;
      lg_r <= 5'd9;
    end else if (wr_en) begin
      if (paddr[2] == fcc_pkg::REG_CLUSTER_COUNT) begin
        cc_r <= pwdata[12:0];
      end else begin
        lg_r <= pwdata[4:0];
      end
    end
  end

  assign old_cnt = fcc_pkg::cluster_span(in_old_size, lg_r);
  assign new_cnt = fcc_pkg::cluster_span(in_new_size, lg_r);

  fcc_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .mreq    (mreq),
    .rdata_r (rdata)
  );

  fcc_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .kind          (in_kind),
    .entry_index   (in_entry_index),
    .entry_value   (in_entry_value),
    .start_cluster (in_start_cluster),
    .old_cnt       (old_cnt),
    .new_cnt       (new_cnt),
    .cluster_count (cc_r),
    .mreq          (mreq),
    .rdata         (rdata),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_value     (out_value)
  );

endmodule

// ----- tb/fcc_checker.sv -----
// Checker of the cluster chain allocator: mirrors the table, predicts each result beat, compares.
module fcc_checker
  import fcc_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [11:0] in_entry_index,
  input  logic [15:0] in_entry_value,
  input  logic [15:0] in_start_cluster,
  input  logic [31:0] in_old_size,
  input  logic [31:0] in_new_size,
  input  logic        out_strobe,
  input  logic        out_status,
  input  logic [15:0] out_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          waiting,
  output int          items_seen,
  output int          extend_fails
);

  typedef struct packed {
    logic        status;
    logic [15:0] value;
  } resp_t;

  logic [15:0] fat [TABLE_DEPTH];
  logic [15:0] scratch_fat [TABLE_DEPTH];
  logic [12:0] n_clusters;
  logic [4:0]  size_log2;
  resp_t       pending_resp [$];

  function automatic longint unsigned clusters_of(input logic [31:0] size);
    longint unsigned s;
    longint unsigned mask;
    s = 64'(size);
    mask = (64'd1 << size_log2) - 64'd1;
    return (s >> size_log2) + (((s & mask) != 0) ? 64'd1 : 64'd0);
  endfunction

  function automatic bit link_ends(input int unsigned link);
    return link >= 32'(END_LOW) || link == 32'(BAD_MARK) || link >= TABLE_DEPTH;
  endfunction

  function automatic int unsigned chain_end(input bit on_scratch, input int unsigned first,
                                            input longint unsigned hops);
    int unsigned cur;
    int unsigned nxt;
    longint unsigned i;
    cur = first;
    for (i = 1; i < hops; i++) begin
      nxt = on_scratch ? scratch_fat[cur] : fat[cur];
      if (link_ends(nxt)) break;
      cur = nxt;
    end
    return cur;
  endfunction

  function automatic logic [15:0] shrink_chain(input int unsigned first,
                                               input longint unsigned oldc,
                                               input longint unsigned newc);
    int unsigned cur;
    int unsigned tail;
    int unsigned nxt;
    int unsigned freed;
    freed = 0;
    if (newc >= oldc) return 16'd0;
    cur = chain_end(1'b0, first, newc);
    tail = fat[cur];
    fat[cur] = END_MARK;
    while (tail != 32'(FREE_ENTRY) && !link_ends(tail)) begin
      nxt = fat[tail];
      fat[tail] = FREE_ENTRY;
      tail = nxt;
      freed++;
    end
    return 16'(freed);
  endfunction

  function automatic resp_t extend_chain(input int unsigned first,
                                         input longint unsigned oldc,
                                         input longint unsigned newc);
    resp_t r;
    int unsigned prev;
    int unsigned lim;
    int unsigned f;
    int unsigned added;
    longint unsigned k;
    r = '0;
    added = 0;
    if (newc <= oldc) return r;
    scratch_fat = fat;
    prev = chain_end(1'b1, first, oldc);
    lim = (n_clusters < TABLE_DEPTH) ? n_clusters : TABLE_DEPTH;
    for (k = oldc; k < newc; k++) begin
      f = FIRST_DATA;
      while (f < lim && scratch_fat[f] != FREE_ENTRY) f++;
      if (f >= lim) begin
        r.status = 1'b1;
        return r;
      end
      scratch_fat[prev] = 16'(f);
      scratch_fat[f] = END_MARK;
      prev = f;
      added++;
    end
    fat = scratch_fat;
    r.value = 16'(added);
    return r;
  endfunction

  function automatic resp_t predict_item(input logic [1:0] kind, input logic [11:0] idx,
                                         input logic [15:0] val, input logic [15:0] first,
                                         input logic [31:0] old_size,
                                         input logic [31:0] new_size);
    resp_t r;
    r = '0;
    case (kind)
      K_WRITE: begin
        if (idx < TABLE_DEPTH) fat[idx] = val;
      end
      K_READ: begin
        if (idx < TABLE_DEPTH) r.value = fat[idx];
      end
      K_EXTEND: begin
        if (first < TABLE_DEPTH)
          r = extend_chain(first, clusters_of(old_size), clusters_of(new_size));
      end
      default: begin
        if (first < TABLE_DEPTH)
          r.value = shrink_chain(first, clusters_of(old_size), clusters_of(new_size));
      end
    endcase
    return r;
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    items_seen = 0;
    extend_fails = 0;
  end

  assign waiting = pending_resp.size();

  always @(posedge clk) begin
    resp_t want;
    resp_t got;
    if (!rst_n) begin
      foreach (fat[i]) fat[i] = FREE_ENTRY;
      n_clusters = 13'd4096;
      size_log2 = 5'd9;
      pending_resp.delete();
    end else begin
      if (out_strobe) begin
        if (pending_resp.size() == 0) begin
          report("unexpected beat value", out_value, 16'd0);
        end else begin
          want = pending_resp.pop_front();
          if (out_status != want.status) report("status", 16'(out_status), 16'(want.status));
          if (out_value != want.value) report("value", out_value, want.value);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_CLUSTER_COUNT) n_clusters = pwdata[12:0];
        else size_log2 = pwdata[4:0];
      end
      if (start && !busy) begin
        got = predict_item(in_kind, in_entry_index, in_entry_value, in_start_cluster,
                           in_old_size, in_new_size);
        if (got.status) extend_fails++;
        items_seen++;
        pending_resp.push_back(got);
      end
    end
  end

  final begin
    if (pending_resp.size() != 0) $display("%0d result beats never arrived", pending_resp.size());
  end

endmodule

// ----- tb/fat_cluster_chain_resize_tb.sv -----
// Top of the cluster chain allocator testbench: clock, reset, stimulus, watchdog and verdict.
module fat_cluster_chain_resize_tb;
  import fcc_pkg::*;

  localparam int IDLE_LIMIT = 10000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [11:0] in_entry_index;
  logic [15:0] in_entry_value;
  logic [15:0] in_start_cluster;
  logic [31:0] in_old_size;
  logic [31:0] in_new_size;
  logic        out_strobe;
  logic        out_status;
  logic [15:0] out_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          waiting;
  int          items_seen;
  int          extend_fails;
  int          idle_cycles;
  int          n_clusters_now;
  int          log2_now;

  fat_cluster_chain_resize dut (.*);

  fcc_checker chk (
    .clk, .rst_n, .start, .busy, .in_kind, .in_entry_index, .in_entry_value,
    .in_start_cluster, .in_old_size, .in_new_size, .out_strobe, .out_status, .out_value,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .waiting, .items_seen, .extend_fails
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d beats outstanding", waiting);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [11:0] idx,
                           input logic [15:0] val, input logic [15:0] first,
                           input logic [31:0] old_size, input logic [31:0] new_size);
    int gap;
    gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_start_cluster <= first;
    in_old_size <= old_size;
    in_new_size <= new_size;
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (waiting != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input int count, input int log2);
    settle();
    write_reg(3'd0, 32'(count));
    write_reg(3'd4, 32'(log2));
    n_clusters_now = count;
    log2_now = log2;
  endtask

  function automatic logic [31:0] pick_size(input bit full_range);
    if (full_range) return $urandom;
    return 32'($urandom_range(0, 12 << log2_now));
  endfunction

  task automatic random_items(input int count, input int full_pct);
    int r;
    logic [15:0] val;
    logic [15:0] first;
    logic [11:0] idx;
    bit full;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      full = $urandom_range(0, 99) < full_pct;
      idx = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0,
            n_clusters_now + 8 < 4095 ? n_clusters_now + 8 : 4095));
      case ($urandom_range(0, 7))
        0: val = $urandom;
        1: val = END_MARK;
        2: val = BAD_MARK;
        3: val = FREE_ENTRY;
        default: val = 16'($urandom_range(0, n_clusters_now + 4));
      endcase
      first = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0,
              n_clusters_now < 4095 ? n_clusters_now : 4095));
      if (r < 30) send_item(K_WRITE, idx, val, first, pick_size(full), pick_size(full));
      else if (r < 48) send_item(K_READ, idx, val, first, pick_size(full), pick_size(full));
      else if (r < 75) send_item(K_EXTEND, idx, val, first, pick_size(full), pick_size(full));
      else send_item(K_SHRINK, idx, val, first, pick_size(full), pick_size(full));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = K_WRITE;
    in_entry_index = '0;
    in_entry_value = '0;
    in_start_cluster = '0;
    in_old_size = '0;
    in_new_size = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    n_clusters_now = 4096;
    log2_now = 9;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    configure(64, 9);
    send_item(K_WRITE, 12'd2, 16'd3, 16'd0, 32'd0, 32'd0);
    send_item(K_WRITE, 12'd3, 16'd4, 16'd0, 32'd0, 32'd0);
    send_item(K_WRITE, 12'd4, END_MARK, 16'd0, 32'd0, 32'd0);
    send_item(K_READ, 12'd3, 16'd0, 16'd0, 32'd0, 32'd0);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'd2, 32'd1536, 32'd2560);
    send_item(K_SHRINK, 12'd0, 16'd0, 16'd2, 32'd2560, 32'd1);
    send_item(K_SHRINK, 12'd0, 16'd0, 16'd2, 32'd512, 32'd0);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'd2, 32'd0, 32'd0);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'hFFFF, 32'd0, 32'd4096);
    send_item(K_SHRINK, 12'd0, 16'd0, 16'd4096, 32'd4096, 32'd0);
    send_item(K_WRITE, 12'd10, BAD_MARK, 16'd0, 32'd0, 32'd0);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'd10, 32'd1537, 32'd2049);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'd21, 32'd1024, 32'd1600);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'd2, 32'd0, 32'hFFFF_FFFF);
    send_item(K_WRITE, 12'd4095, 16'hFFFF, 16'd0, 32'd0, 32'd0);
    send_item(K_READ, 12'd4095, 16'd0, 16'd0, 32'd0, 32'd0);
    send_item(K_READ, 12'd10, 16'd0, 16'd0, 32'd0, 32'd0);
    random_items(45, 0);

    configure(2, 9);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'd5, 32'd0, 32'd512);
    random_items(10, 0);

    configure(4096, 16);
    send_item(K_EXTEND, 12'd0, 16'd0, 16'd40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(K_SHRINK, 12'd0, 16'd0, 16'd2, 32'hFFFF_FFFF, 32'd1);
    random_items(40, 40);

    configure(300, 12);
    random_items(30, 5);

    settle();
    repeat (50) @(negedge clk);
    $display("covered %0d items over four table configurations, %0d extends out of space",
             items_seen, extend_fails);
    if (errors == 0 && waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
